@@ hw/rtl/btut_pkg.sv @@
// btut_pkg: request codes, status and binding-kind codes, default sizes and
// the request/response word types of the binding table with undo trail.
// No dependencies.
package btut_pkg;

    // default table sizes
    localparam int NODE_SLOTS_DEF  = 64;
    localparam int EDGE_SLOTS_DEF  = 64;
    localparam int VAR_SLOTS_DEF   = 64;
    localparam int HANDLE_BITS_DEF = 16;

    // request codes
    localparam logic [3:0] REQ_MAP_NODE   = 4'd0;
    localparam logic [3:0] REQ_MAP_EDGE   = 4'd1;
    localparam logic [3:0] REQ_BIND_INT   = 4'd2;
    localparam logic [3:0] REQ_BIND_LIST  = 4'd3;
    localparam logic [3:0] REQ_UNMAP_NODE = 4'd4;
    localparam logic [3:0] REQ_UNMAP_EDGE = 4'd5;
    localparam logic [3:0] REQ_READ_NODE  = 4'd6;
    localparam logic [3:0] REQ_READ_EDGE  = 4'd7;
    localparam logic [3:0] REQ_READ_VAR   = 4'd8;
    localparam logic [3:0] REQ_CLEAR_ALL  = 4'd9;

    // response status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SAME     = 2'd1;
    localparam logic [1:0] STATUS_CONFLICT = 2'd2;
    localparam logic [1:0] STATUS_RANGE    = 2'd3;

    // binding kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_INT  = 2'd1;
    localparam logic [1:0] KIND_LIST = 2'd2;

    // request word
    typedef struct packed {
        logic [3:0]         req_type;
        logic [5:0]         slot_index;
        logic [15:0]        host_handle;
        logic [6:0]         binding_count;
        logic [5:0]         var_id;
        logic signed [31:0] int_value;
        logic [15:0]        list_handle;
    } req_t;

    // response word
    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        handle_out;
        logic [1:0]         kind_out;
        logic signed [31:0] value_out;
    } rsp_t;

    // requests that address the edge half of the slot table
    function automatic logic is_edge_req(input logic [3:0] t);
        logic r;
        r = (t == REQ_MAP_EDGE) || (t == REQ_UNMAP_EDGE) || (t == REQ_READ_EDGE);
        return r;
    endfunction

endpackage

@@ hw/rtl/binding_table_with_undo_trail.sv @@
// binding_table_with_undo_trail: node/edge slot table and variable table with
// an undo trail for rule matching. Depends on btut_pkg.
// Slot and variable entries live in two synchronous memories.
//
// One request word in, one response word out. A request is taken only while
// the block is idle; map, bind, read, clear-all and unknown requests pass
// through memory read, execute and hand-off to the response register before
// the next acceptance. Unmap pops k bindings, where k is the slot's binding
// count cut short when the trail empties: an execute state, then a pop state
// and a pop-wait state per pop, a pop check that ends the loop, then
// hand-off and idle. Each pop unbinds the top variable and reads its entry
// in the variable memory to find the next trail entry beneath it, as the
// trail is kept as a linked stack inside that memory. The response register
// lets the next request be accepted while the previous response waits; that
// next request then holds in hand-off until the previous response has been
// taken. All reset-to-zero tables use per-entry valid bits, so reset and
// clear-all take effect at once with no clearing pass. HANDLE_BITS masks
// stored handles.
module binding_table_with_undo_trail #(
    parameter int NODE_SLOTS  = btut_pkg::NODE_SLOTS_DEF,
    parameter int EDGE_SLOTS  = btut_pkg::EDGE_SLOTS_DEF,
    parameter int VAR_SLOTS   = btut_pkg::VAR_SLOTS_DEF,
    parameter int HANDLE_BITS = btut_pkg::HANDLE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  btut_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output btut_pkg::rsp_t rsp
);

    // reachable sizes: indexes in the request word are six bits
    localparam int NODE_D  = (NODE_SLOTS < 64) ? NODE_SLOTS : 64;
    localparam int EDGE_D  = (EDGE_SLOTS < 64) ? EDGE_SLOTS : 64;
    localparam int VAR_D   = (VAR_SLOTS < 64) ? VAR_SLOTS : 64;
    localparam int SLOT_D  = (NODE_D > EDGE_D) ? NODE_D : EDGE_D;
    localparam int SLOT_W  = (SLOT_D > 1) ? $clog2(SLOT_D) : 1;
    localparam int SMEM_D  = 1 << (SLOT_W + 1);
    localparam int ID_W    = (VAR_D > 1) ? $clog2(VAR_D) : 1;
    localparam int VMEM_D  = 1 << ID_W;
    localparam int CNT_W   = $clog2(VAR_D + 1);
    localparam int HW      = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

    // control states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EXEC     = 3'd1;
    localparam logic [2:0] ST_POP      = 3'd2;
    localparam logic [2:0] ST_POP_WAIT = 3'd3;
    localparam logic [2:0] ST_FIN      = 3'd4;

    typedef struct packed {
        logic [HW-1:0] handle;
        logic [6:0]    count;
    } slot_ent_t;

    // link: id of the variable beneath this one on the trail
    typedef struct packed {
        logic [1:0]      kind;
        logic [31:0]     value;
        logic [ID_W-1:0] link;
    } var_ent_t;

    // memories
    slot_ent_t slot_mem [SMEM_D];
    var_ent_t  var_mem  [VMEM_D];

    logic [2:0]        state_reg, state_next;
    btut_pkg::req_t    req_reg, req_next;
    logic              oor_reg, oor_next;
    logic [SMEM_D-1:0] slot_vld_reg, slot_vld_next;
    logic [VMEM_D-1:0] var_bound_reg, var_bound_next;
    logic [CNT_W-1:0]  trail_top_reg, trail_top_next;
    logic [ID_W-1:0]   top_id_reg, top_id_next;
    logic [6:0]        pop_cnt_reg, pop_cnt_next;
    btut_pkg::rsp_t    res_reg, res_next;
    btut_pkg::rsp_t    rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    slot_ent_t         slot_rd_reg;
    var_ent_t          var_rd_reg;

    logic              accept;
    logic              in_oor;
    logic [SLOT_W:0]   slot_ra;
    logic [SLOT_W:0]   slot_wa;
    logic              slot_we;
    slot_ent_t         slot_wd;
    logic [ID_W-1:0]   var_ra;
    logic [ID_W-1:0]   vid;
    logic              var_we;
    var_ent_t          var_wd;
    logic [1:0]        bind_kind;
    logic [31:0]       bind_val;
    logic              node_oor;
    logic              edge_oor;
    logic              var_oor;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // range check of the incoming request
    assign node_oor = {26'd0, req.slot_index} >= 32'(NODE_D);
    assign edge_oor = {26'd0, req.slot_index} >= 32'(EDGE_D);
    assign var_oor  = {26'd0, req.var_id} >= 32'(VAR_D);

    always_comb
    begin
        case (req.req_type) inside
            btut_pkg::REQ_MAP_NODE, btut_pkg::REQ_UNMAP_NODE, btut_pkg::REQ_READ_NODE:
                in_oor = node_oor;
            btut_pkg::REQ_MAP_EDGE, btut_pkg::REQ_UNMAP_EDGE, btut_pkg::REQ_READ_EDGE:
                in_oor = edge_oor;
            btut_pkg::REQ_BIND_INT, btut_pkg::REQ_BIND_LIST, btut_pkg::REQ_READ_VAR:
                in_oor = var_oor;
            default:
                in_oor = 1'b0;
        endcase
    end

    // memory addresses: reads issued at acceptance, writes from the held request
    assign slot_ra = {btut_pkg::is_edge_req(req.req_type), req.slot_index[SLOT_W-1:0]};
    assign slot_wa = {btut_pkg::is_edge_req(req_reg.req_type), req_reg.slot_index[SLOT_W-1:0]};
    assign vid     = req_reg.var_id[ID_W-1:0];
    assign var_ra  = (state_reg == ST_POP) ? top_id_reg : req.var_id[ID_W-1:0];

    // value to bind or compare
    assign bind_kind = (req_reg.req_type == btut_pkg::REQ_BIND_INT) ?
                       btut_pkg::KIND_INT : btut_pkg::KIND_LIST;
    assign bind_val  = (req_reg.req_type == btut_pkg::REQ_BIND_INT) ?
                       req_reg.int_value : 32'(req_reg.list_handle[HW-1:0]);

    assign slot_wd.handle = req_reg.host_handle[HW-1:0];
    assign slot_wd.count  = req_reg.binding_count;
    assign var_wd.kind    = bind_kind;
    assign var_wd.value   = bind_val;
    assign var_wd.link    = top_id_reg;

    // next-state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        oor_next       = oor_reg;
        slot_vld_next  = slot_vld_reg;
        var_bound_next = var_bound_reg;
        trail_top_next = trail_top_reg;
        top_id_next    = top_id_reg;
        pop_cnt_next   = pop_cnt_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        slot_we        = 1'b0;
        var_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req;
                    oor_next   = in_oor;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_next   = '0;
                state_next = ST_FIN;
                if (oor_reg)
                begin
                    res_next.status = btut_pkg::STATUS_RANGE;
                end
                else
                begin
                    case (req_reg.req_type) inside
                        btut_pkg::REQ_MAP_NODE, btut_pkg::REQ_MAP_EDGE:
                        begin
                            slot_we                = 1'b1;
                            slot_vld_next[slot_wa] = 1'b1;
                        end
                        btut_pkg::REQ_BIND_INT, btut_pkg::REQ_BIND_LIST:
                        begin
                            if (!var_bound_reg[vid])
                            begin
                                // new binding, pushed on the trail
                                var_we              = 1'b1;
                                var_bound_next[vid] = 1'b1;
                                if (trail_top_reg < CNT_W'(VAR_D))
                                begin
                                    top_id_next    = vid;
                                    trail_top_next = trail_top_reg + CNT_W'(1);
                                end
                            end
                            else if (var_rd_reg.kind == bind_kind &&
                                     var_rd_reg.value == bind_val)
                            begin
                                res_next.status = btut_pkg::STATUS_SAME;
                            end
                            else
                            begin
                                res_next.status = btut_pkg::STATUS_CONFLICT;
                            end
                        end
                        btut_pkg::REQ_UNMAP_NODE, btut_pkg::REQ_UNMAP_EDGE:
                        begin
                            slot_vld_next[slot_wa] = 1'b0;
                            pop_cnt_next = slot_vld_reg[slot_wa] ? slot_rd_reg.count : 7'd0;
                            state_next   = ST_POP;
                        end
                        btut_pkg::REQ_READ_NODE, btut_pkg::REQ_READ_EDGE:
                        begin
                            if (slot_vld_reg[slot_wa])
                            begin
                                res_next.handle_out = 16'(slot_rd_reg.handle);
                            end
                        end
                        btut_pkg::REQ_READ_VAR:
                        begin
                            if (var_bound_reg[vid])
                            begin
                                res_next.kind_out  = var_rd_reg.kind;
                                res_next.value_out = var_rd_reg.value;
                            end
                        end
                        btut_pkg::REQ_CLEAR_ALL:
                        begin
                            slot_vld_next  = '0;
                            var_bound_next = '0;
                            trail_top_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // unbind the top of the trail, then fetch its link
            ST_POP:
            begin
                if (pop_cnt_reg == 7'd0 || trail_top_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    var_bound_next[top_id_reg] = 1'b0;
                    trail_top_next             = trail_top_reg - CNT_W'(1);
                    pop_cnt_next               = pop_cnt_reg - 7'd1;
                    state_next                 = ST_POP_WAIT;
                end
            end

            ST_POP_WAIT:
            begin
                top_id_next = var_rd_reg.link;
                state_next  = ST_POP;
            end

            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_vld_reg  <= '0;
            var_bound_reg <= '0;
            trail_top_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_vld_reg  <= slot_vld_next;
            var_bound_reg <= var_bound_next;
            trail_top_reg <= trail_top_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        oor_reg     <= oor_next;
        top_id_reg  <= top_id_next;
        pop_cnt_reg <= pop_cnt_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    // slot memory: node half and edge half
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd_reg <= slot_mem[slot_ra];
    end

    // variable memory: kind, value and trail link
    always_ff @(posedge clk)
    begin
        if (var_we)
        begin
            var_mem[vid] <= var_wd;
        end
        var_rd_reg <= var_mem[var_ra];
    end

`ifndef ASSERT_OFF
    // every bound variable sits exactly once on the trail
    a_bound_matches_trail: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(var_bound_reg) == int'(trail_top_reg))
        else $error("bound variable count differs from trail depth");

    a_trail_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        trail_top_reg <= CNT_W'(VAR_D))
        else $error("trail depth beyond variable count");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req_ready)
        else $error("request accepted while another is in flight");

    // pop loop stops on exhausted count or empty trail
    a_pop_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP && (pop_cnt_reg == 7'd0 || trail_top_reg == '0))
        |=> state_reg == ST_FIN)
        else $error("pop loop did not stop");

    // the variable being unlinked has already been unbound
    a_pop_unbinds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POP_WAIT |-> !var_bound_reg[top_id_reg])
        else $error("popped variable still bound");
`endif

endmodule

@@ tb/sv/match_state_scoreboard_pkg.sv @@
// match_state_scoreboard_pkg: scoreboard class that mirrors the slot, variable
// and undo trail tables and checks every response word in order.
// Depends on btut_pkg for the word types, codes and table sizes.
package match_state_scoreboard_pkg;

    import btut_pkg::*;

    class match_state_scoreboard;

        // mirrored tables
        logic [15:0] node_handle_of [NODE_SLOTS_DEF];
        logic [6:0]  node_count_of  [NODE_SLOTS_DEF];
        logic [15:0] edge_handle_of [EDGE_SLOTS_DEF];
        logic [6:0]  edge_count_of  [EDGE_SLOTS_DEF];
        logic [1:0]  var_kind_of    [VAR_SLOTS_DEF];
        logic [31:0] var_value_of   [VAR_SLOTS_DEF];
        logic [5:0]  trail_ids      [VAR_SLOTS_DEF];
        int unsigned trail_depth;

        // responses owed by the block, oldest first
        rsp_t        awaited_rsp [$];
        int unsigned mismatches;

        function new();
            wipe();
            mismatches = 0;
        endfunction

        // reset and clear-all state
        function void wipe();
            for (int i = 0; i < NODE_SLOTS_DEF; i++)
            begin
                node_handle_of[i] = '0;
                node_count_of[i]  = '0;
            end
            for (int i = 0; i < EDGE_SLOTS_DEF; i++)
            begin
                edge_handle_of[i] = '0;
                edge_count_of[i]  = '0;
            end
            for (int i = 0; i < VAR_SLOTS_DEF; i++)
            begin
                var_kind_of[i]  = KIND_NONE;
                var_value_of[i] = '0;
                trail_ids[i]    = '0;
            end
            trail_depth = 0;
        endfunction

        // pop up to count ids off the trail, stopping when it runs dry
        function void unwind(logic [6:0] count);
            for (int k = 0; k < count && trail_depth > 0; k++)
            begin
                trail_depth--;
                var_kind_of[trail_ids[trail_depth]] = KIND_NONE;
            end
        endfunction

        // new binding, equal rebind or conflict (a kind mismatch conflicts)
        function logic [1:0] bind_variable(logic [5:0] id, logic [1:0] kind,
                                           logic [31:0] value);
            if (var_kind_of[id] == KIND_NONE)
            begin
                var_kind_of[id]  = kind;
                var_value_of[id] = value;
                if (trail_depth < VAR_SLOTS_DEF)
                begin
                    trail_ids[trail_depth] = id;
                    trail_depth++;
                end
                return STATUS_OK;
            end
            if (var_kind_of[id] == kind && var_value_of[id] == value)
                return STATUS_SAME;
            return STATUS_CONFLICT;
        endfunction

        // accepted request word: update tables, queue the response it owes
        // (six-bit indexes always land inside the 64-entry tables)
        function void note_request(req_t w);
            rsp_t owed;
            owed = '0;
            case (w.req_type)
                REQ_MAP_NODE:
                begin
                    node_handle_of[w.slot_index] = w.host_handle;
                    node_count_of[w.slot_index]  = w.binding_count;
                end
                REQ_MAP_EDGE:
                begin
                    edge_handle_of[w.slot_index] = w.host_handle;
                    edge_count_of[w.slot_index]  = w.binding_count;
                end
                REQ_BIND_INT:
                    owed.status = bind_variable(w.var_id, KIND_INT, w.int_value);
                REQ_BIND_LIST:
                    owed.status = bind_variable(w.var_id, KIND_LIST, {16'd0, w.list_handle});
                REQ_UNMAP_NODE:
                begin
                    node_handle_of[w.slot_index] = '0;
                    unwind(node_count_of[w.slot_index]);
                    node_count_of[w.slot_index] = '0;
                end
                REQ_UNMAP_EDGE:
                begin
                    edge_handle_of[w.slot_index] = '0;
                    unwind(edge_count_of[w.slot_index]);
                    edge_count_of[w.slot_index] = '0;
                end
                REQ_READ_NODE:
                    owed.handle_out = node_handle_of[w.slot_index];
                REQ_READ_EDGE:
                    owed.handle_out = edge_handle_of[w.slot_index];
                REQ_READ_VAR:
                begin
                    owed.kind_out = var_kind_of[w.var_id];
                    if (var_kind_of[w.var_id] != KIND_NONE)
                        owed.value_out = var_value_of[w.var_id];
                end
                REQ_CLEAR_ALL:
                    wipe();
                default:
                    ;
            endcase
            awaited_rsp.push_back(owed);
        endfunction

        // accepted response word against the oldest owed one
        function void check_response(rsp_t got);
            rsp_t want;
            if (awaited_rsp.size() == 0)
            begin
                $error("response word with none awaited: status %0d handle %0h",
                       got.status, got.handle_out);
                mismatches++;
                return;
            end
            want = awaited_rsp.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.handle_out !== want.handle_out)
            begin
                $error("handle_out: expected %0h, got %0h", want.handle_out, got.handle_out);
                mismatches++;
            end
            if (got.kind_out !== want.kind_out)
            begin
                $error("kind_out: expected %0d, got %0d", want.kind_out, got.kind_out);
                mismatches++;
            end
            if (got.value_out !== want.value_out)
            begin
                $error("value_out: expected %0d, got %0d", want.value_out, got.value_out);
                mismatches++;
            end
        endfunction

    endclass

endpackage

@@ tb/sv/binding_table_with_undo_trail_test.sv @@
// binding_table_with_undo_trail_test: directed and random request streams for
// the binding table with undo trail, checked word by word by the scoreboard.
// Depends on btut_pkg, match_state_scoreboard_pkg and the block itself.
module binding_table_with_undo_trail_test;

    import btut_pkg::*;
    import match_state_scoreboard_pkg::*;

    localparam int         WORD_BUDGET      = 1200;
    localparam int         HOLD_OFF         = 250;
    localparam int         TAIL_CYCLES      = 200;
    localparam logic [3:0] REQ_FIRST_UNUSED = 4'd10;
    localparam logic [3:0] REQ_LAST_UNUSED  = 4'd15;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    match_state_scoreboard sb = new();

    int         words_sent      = 0;
    int         hold_off_cycles = 0;
    bit         send_calm       = 1'b0;
    bit         recv_calm       = 1'b0;
    logic [6:0] mapped_slots [$];     // {edge, slot} of recent mappings

    binding_table_with_undo_trail u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // value pickers leaning on the extremes
    function automatic logic [31:0] pick_int();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_handle();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // request word with every field random
    function automatic req_t noise_word();
        req_t w;
        w.req_type      = 4'($urandom_range(0, 15));
        w.slot_index    = 6'($urandom_range(0, 63));
        w.host_handle   = pick_handle();
        w.binding_count = 7'($urandom_range(0, 64));
        w.var_id        = 6'($urandom_range(0, 63));
        w.int_value     = pick_int();
        w.list_handle   = pick_handle();
        return w;
    endfunction

    // offer one request word after a random gap, return once accepted
    task automatic send_request(input req_t w);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(w);
        words_sent++;
    endtask

    task automatic issue(logic [3:0] kind, logic [5:0] slot, logic [15:0] handle,
                         logic [6:0] count, logic [5:0] id, logic [31:0] ival,
                         logic [15:0] lh);
        req_t w;
        w.req_type      = kind;
        w.slot_index    = slot;
        w.host_handle   = handle;
        w.binding_count = count;
        w.var_id        = id;
        w.int_value     = ival;
        w.list_handle   = lh;
        send_request(w);
    endtask

    // stop offering and wait until every owed response has come back
    task automatic settle();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.awaited_rsp.size() != 0);
    endtask

    // bind a random variable, sometimes repeating its current binding
    task automatic bind_one();
        req_t       w;
        logic [5:0] id;
        w        = noise_word();
        id       = 6'($urandom_range(0, 63));
        w.var_id = id;
        w.req_type = $urandom_range(0, 1) ? REQ_BIND_LIST : REQ_BIND_INT;
        if (sb.var_kind_of[id] != KIND_NONE && $urandom_range(0, 2) == 0)
        begin
            if (sb.var_kind_of[id] == KIND_INT)
            begin
                w.req_type  = REQ_BIND_INT;
                w.int_value = sb.var_value_of[id];
            end
            else
            begin
                w.req_type    = REQ_BIND_LIST;
                w.list_handle = sb.var_value_of[id][15:0];
            end
        end
        send_request(w);
    endtask

    task automatic read_one();
        req_t w;
        w = noise_word();
        case ($urandom_range(0, 2))
            0:       w.req_type = REQ_READ_NODE;
            1:       w.req_type = REQ_READ_EDGE;
            default: w.req_type = REQ_READ_VAR;
        endcase
        send_request(w);
    endtask

    // unmap the latest mapping mostly, any slot now and then
    task automatic unmap_one();
        req_t       w;
        logic [6:0] entry;
        w = noise_word();
        if (mapped_slots.size() != 0 && $urandom_range(0, 4) != 0)
            entry = mapped_slots.pop_back();
        else
            entry = 7'($urandom_range(0, 127));
        w.req_type   = entry[6] ? REQ_UNMAP_EDGE : REQ_UNMAP_NODE;
        w.slot_index = entry[5:0];
        send_request(w);
    endtask

    // map a slot, make its bindings, maybe undo a mapping
    task automatic match_episode();
        req_t       w;
        logic       on_edge;
        logic [5:0] slot;
        int         n;
        on_edge = 1'($urandom_range(0, 1));
        slot    = 6'($urandom_range(0, 63));
        n       = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 64) : $urandom_range(0, 4);
        w               = noise_word();
        w.req_type      = on_edge ? REQ_MAP_EDGE : REQ_MAP_NODE;
        w.slot_index    = slot;
        w.binding_count = 7'(n);
        send_request(w);
        mapped_slots.push_back({on_edge, slot});
        repeat (n)
        begin
            bind_one();
            if ($urandom_range(0, 2) == 0)
                read_one();
        end
        if ($urandom_range(0, 9) < 4)
            unmap_one();
    endtask

    // directed words: extremes, every request and the corner cases
    task automatic directed_words();
        issue(REQ_READ_NODE, 6'd0, 16'h0, 7'd0, 6'd0, 32'h0, 16'h0);
        issue(REQ_READ_EDGE, 6'd63, 16'h0, 7'd0, 6'd0, 32'h0, 16'h0);
        issue(REQ_READ_VAR, 6'd0, 16'h0, 7'd0, 6'd63, 32'h0, 16'h0);
        issue(REQ_MAP_NODE, 6'd63, 16'hFFFF, 7'd64, 6'd0, 32'h0, 16'h0);
        issue(REQ_MAP_EDGE, 6'd0, 16'h0, 7'd0, 6'd0, 32'h0, 16'h0);
        // equal rebind, value conflict, kind mismatch
        issue(REQ_BIND_INT, 6'd0, 16'h0, 7'd0, 6'd0, 32'h8000_0000, 16'h0);
        issue(REQ_BIND_INT, 6'd0, 16'h0, 7'd0, 6'd0, 32'h8000_0000, 16'h0);
        issue(REQ_BIND_INT, 6'd0, 16'h0, 7'd0, 6'd0, 32'h7FFF_FFFF, 16'h0);
        issue(REQ_BIND_LIST, 6'd0, 16'h0, 7'd0, 6'd0, 32'h0, 16'h0);
        issue(REQ_BIND_LIST, 6'd0, 16'h0, 7'd0, 6'd63, 32'h0, 16'hFFFF);
        // same number bound as a list does not match an integer
        issue(REQ_BIND_INT, 6'd0, 16'h0, 7'd0, 6'd63, 32'h0000_FFFF, 16'h0);
        issue(REQ_BIND_LIST, 6'd0, 16'h0, 7'd0, 6'd63, 32'h0, 16'hFFFF);
        issue(REQ_READ_VAR, 6'd0, 16'h0, 7'd0, 6'd0, 32'h0, 16'h0);
        issue(REQ_READ_VAR, 6'd0, 16'h0, 7'd0, 6'd63, 32'h0, 16'h0);
        issue(REQ_READ_NODE, 6'd63, 16'h0, 7'd0, 6'd0, 32'h0, 16'h0);
        // remap keeps the bindings, then unmap pops only the new count
        issue(REQ_MAP_NODE, 6'd63, 16'h1234, 7'd1, 6'd0, 32'h0, 16'h0);
        issue(REQ_LAST_UNUSED, 6'h3F, 16'hFFFF, 7'd64, 6'h3F, 32'hFFFF_FFFF, 16'hFFFF);
        issue(REQ_FIRST_UNUSED, 6'd0, 16'h0, 7'd0, 6'd0, 32'h0, 16'h0);
        issue(REQ_UNMAP_NODE, 6'd63, 16'h0, 7'd0, 6'd0, 32'h0, 16'h0);
        issue(REQ_READ_VAR, 6'd0, 16'h0, 7'd0, 6'd63, 32'h0, 16'h0);
        // unmap asking for more pops than the trail holds
        issue(REQ_MAP_EDGE, 6'd5, 16'hA5A5, 7'd64, 6'd0, 32'h0, 16'h0);
        issue(REQ_UNMAP_EDGE, 6'd5, 16'h0, 7'd0, 6'd0, 32'h0, 16'h0);
        issue(REQ_READ_VAR, 6'd0, 16'h0, 7'd0, 6'd0, 32'h0, 16'h0);
        issue(REQ_READ_EDGE, 6'd5, 16'h0, 7'd0, 6'd0, 32'h0, 16'h0);
        // clear-all wipes bindings and slots
        issue(REQ_BIND_INT, 6'd0, 16'h0, 7'd0, 6'd5, 32'hFFFF_FFFF, 16'h0);
        issue(REQ_CLEAR_ALL, 6'd0, 16'h0, 7'd0, 6'd0, 32'h0, 16'h0);
        issue(REQ_READ_VAR, 6'd0, 16'h0, 7'd0, 6'd5, 32'h0, 16'h0);
    endtask

    // request side: reset, directed words, random stream, end of run
    initial
    begin : request_side
        bit held;
        bit paused;
        int pick;
        held      = 1'b0;
        paused    = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();

        while (words_sent < WORD_BUDGET)
        begin
            // long receiver hold-off while words keep coming
            if (!held && words_sent >= 350)
            begin
                hold_off_cycles = HOLD_OFF;
                held = 1'b1;
            end
            // one full pause until the block has answered everything
            if (!paused && words_sent >= 700)
            begin
                settle();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 2)
            begin
                issue(REQ_CLEAR_ALL, 6'd0, 16'h0, 7'd0, 6'd0, 32'h0, 16'h0);
                mapped_slots.delete();
            end
            else if (pick < 80)
                match_episode();
            else
                send_request(noise_word());
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.awaited_rsp.size() == 0)
            $display("binding_table_with_undo_trail regression: pass");
        else
            $display("binding_table_with_undo_trail regression: fail");
        $finish;
    end

    // response side: random stalls, an occasional long hold-off
    initial
    begin : response_side
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_cycles != 0)
            begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
                stall = recv_calm ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 39) == 0)
                recv_calm = !recv_calm;
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            sb.check_response(rsp);
        end
    end

    // run limit
    initial
    begin : watchdog
        #1_600_000;
        $display("binding_table_with_undo_trail regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/btut_pkg.sv
hw/rtl/binding_table_with_undo_trail.sv
tb/sv/match_state_scoreboard_pkg.sv
tb/sv/binding_table_with_undo_trail_test.sv
